// File: sv/expiring_block_list_table_top_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef EXPIRING_BLOCK_LIST_TABLE_TOP_MACROS_SVH
`define EXPIRING_BLOCK_LIST_TABLE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define EBLT_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("eblt assertion failed");

// Next-cycle implication, disabled during reset.
`define EBLT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("eblt assertion failed");

`endif

// File: sv/eblt_pkg.sv
package eblt_pkg;

    localparam int ENTRIES_DEFAULT = 64;

    localparam int ADDR_W = 64;
    localparam int SECS_W = 16;
    localparam int NOW_W  = 31;
    localparam int EXP_W  = 32;
    localparam int SLOT_W = 6;

    localparam int S_TDATA_W = 112;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 8;

    localparam logic [EXP_W-1:0] MS_PER_SECOND = 32'd1000;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

endpackage

// File: sv/eblt_ram.sv
module eblt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/expiring_block_list_table_top.sv
// Expiring block list: a table of ENTRIES banned 64-bit addresses, each with an expiry in ms.
// Input channel s_*: one word per command. s_tuser carries the command (0 add, 1 query);
// s_tdata carries the address, ban length in seconds and current time in ms.
// Result channel m_*: exactly one word per command, in order.
// An add takes the first free entry (expiry zero or before now), or else evicts the entry
// with the smallest expiry, and stores expiry = now + seconds * 1000.
// A query reports the first entry holding the address whose expiry is later than now.
// Every command scans the whole table one entry per cycle through the expiry and address
// RAMs (one read port each, registered read), and the result is registered in ST_FINISH;
// a new word is accepted only in ST_IDLE, after the previous command has been scanned.
// After aresetn goes high the expiry RAM is swept to zero, one entry a cycle, through all
// ENTRIES entries; s_tready stays low during that pass. The address RAM is not cleared.
// The result sits in an output register: the next command is accepted and scanned while a
// result waits; a stalled receiver holds the block only when the next result is ready.
`include "expiring_block_list_table_top_macros.svh"

module expiring_block_list_table_top #(
    parameter int ENTRIES = eblt_pkg::ENTRIES_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [63:0] address, [79:64] ban_seconds, [110:80] now_ms, [111] zero
    input  logic [eblt_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] command
    input  logic [eblt_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] banned, [6:1] slot, [7] evicted
    output logic [eblt_pkg::M_TDATA_W-1:0] m_tdata
);

    import eblt_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [IW-1:0]     clr_idx_reg, clr_idx_next;
    logic [IW-1:0]     rd_idx_reg, rd_idx_next;
    logic              issue_reg, issue_next;
    logic              chk_valid_reg, chk_valid_next;
    logic [IW-1:0]     chk_idx_reg, chk_idx_next;
    logic              cmd_reg, cmd_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [NOW_W-1:0]  now_reg, now_next;
    logic [EXP_W-1:0]  new_exp_reg, new_exp_next;
    logic              found_reg, found_next;
    logic [IW-1:0]     pick_reg, pick_next;
    logic [EXP_W-1:0]  min_exp_reg, min_exp_next;
    logic [IW-1:0]     min_idx_reg, min_idx_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              m_banned_reg, m_banned_next;
    logic [SLOT_W-1:0] m_slot_reg, m_slot_next;
    logic              m_evicted_reg, m_evicted_next;

    logic              exp_we;
    logic [IW-1:0]     exp_waddr;
    logic [EXP_W-1:0]  exp_wdata;
    logic [EXP_W-1:0]  exp_rdata;
    logic              addr_we;
    logic [ADDR_W-1:0] addr_rdata;

    logic              entry_free;
    logic              entry_live;
    logic              out_free;
    logic [IW-1:0]     add_slot;

    eblt_ram #(
        .WIDTH (EXP_W),
        .DEPTH (ENTRIES)
    ) u_exp_ram (
        .clk   (aclk),
        .we    (exp_we),
        .waddr (exp_waddr),
        .wdata (exp_wdata),
        .raddr (rd_idx_reg),
        .rdata (exp_rdata)
    );

    eblt_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (ENTRIES)
    ) u_addr_ram (
        .clk   (aclk),
        .we    (addr_we),
        .waddr (add_slot),
        .wdata (addr_reg),
        .raddr (rd_idx_reg),
        .rdata (addr_rdata)
    );

    assign entry_free = (exp_rdata == '0) || (exp_rdata < EXP_W'(now_reg));
    assign entry_live = (exp_rdata != '0) && (exp_rdata > EXP_W'(now_reg))
                        && (addr_rdata == addr_reg);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign add_slot   = found_reg ? pick_reg : min_idx_reg;

    always_comb begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        rd_idx_next    = rd_idx_reg;
        issue_next     = issue_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        cmd_next       = cmd_reg;
        addr_next      = addr_reg;
        now_next       = now_reg;
        new_exp_next   = new_exp_reg;
        found_next     = found_reg;
        pick_next      = pick_reg;
        min_exp_next   = min_exp_reg;
        min_idx_next   = min_idx_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_banned_next  = m_banned_reg;
        m_slot_next    = m_slot_reg;
        m_evicted_next = m_evicted_reg;
        exp_we         = 1'b0;
        exp_waddr      = add_slot;
        exp_wdata      = new_exp_reg;
        addr_we        = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                exp_we       = 1'b1;
                exp_waddr    = clr_idx_reg;
                exp_wdata    = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next     = s_tuser[0];
                    addr_next    = s_tdata[63:0];
                    now_next     = s_tdata[110:80];
                    new_exp_next = EXP_W'(s_tdata[110:80])
                                   + EXP_W'(s_tdata[79:64]) * MS_PER_SECOND;
                    rd_idx_next  = '0;
                    issue_next   = 1'b1;
                    found_next   = 1'b0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (issue_reg) begin
                    rd_idx_next    = rd_idx_reg + 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = rd_idx_reg;
                    if (rd_idx_reg == LAST_IDX) begin
                        issue_next = 1'b0;
                    end
                end
                if (chk_valid_reg) begin
                    if (cmd_reg == CMD_ADD) begin
                        if (!found_reg && entry_free) begin
                            found_next = 1'b1;
                            pick_next  = chk_idx_reg;
                        end
                        if ((chk_idx_reg == '0) || (exp_rdata < min_exp_reg)) begin
                            min_exp_next = exp_rdata;
                            min_idx_next = chk_idx_reg;
                        end
                    end else begin
                        if (!found_reg && entry_live) begin
                            found_next = 1'b1;
                            pick_next  = chk_idx_reg;
                        end
                    end
                    if (chk_idx_reg == LAST_IDX) begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    if (cmd_reg == CMD_ADD) begin
                        exp_we         = 1'b1;
                        addr_we        = 1'b1;
                        m_banned_next  = 1'b0;
                        m_slot_next    = SLOT_W'(add_slot);
                        m_evicted_next = !found_reg;
                    end else begin
                        m_banned_next  = found_reg;
                        m_slot_next    = found_reg ? SLOT_W'(pick_reg) : '0;
                        m_evicted_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            issue_reg     <= 1'b0;
            chk_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            issue_reg     <= issue_next;
            chk_valid_reg <= chk_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        rd_idx_reg    <= rd_idx_next;
        chk_idx_reg   <= chk_idx_next;
        cmd_reg       <= cmd_next;
        addr_reg      <= addr_next;
        now_reg       <= now_next;
        new_exp_reg   <= new_exp_next;
        found_reg     <= found_next;
        pick_reg      <= pick_next;
        min_exp_reg   <= min_exp_next;
        min_idx_reg   <= min_idx_next;
        m_banned_reg  <= m_banned_next;
        m_slot_reg    <= m_slot_next;
        m_evicted_reg <= m_evicted_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_evicted_reg, m_slot_reg, m_banned_reg};

    `EBLT_ASSERT_NOW(a_clear_ends_at_last, aclk, aresetn,
        (state_reg == ST_CLEAR) && (state_next == ST_IDLE), clr_idx_reg == LAST_IDX)
    `EBLT_ASSERT_NEXT(a_last_check_finishes, aclk, aresetn,
        chk_valid_reg && (chk_idx_reg == LAST_IDX), state_reg == ST_FINISH)
    `EBLT_ASSERT_NEXT(a_read_pipe_index, aclk, aresetn,
        issue_reg && (state_reg == ST_SCAN), chk_valid_reg && (chk_idx_reg == $past(rd_idx_reg)))
    `EBLT_ASSERT_NOW(a_addr_write_on_add, aclk, aresetn,
        addr_we, (state_reg == ST_FINISH) && (cmd_reg == CMD_ADD) && exp_we)
    `EBLT_ASSERT_NOW(a_result_flags, aclk, aresetn,
        m_tvalid_reg, !(m_banned_reg && m_evicted_reg))

endmodule

// File: bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import eblt_pkg::*;

    localparam int ENTRIES = ENTRIES_DEFAULT;
    localparam int RX_HOLD_CYCLES = 900;

    typedef struct packed {
        logic             evicted;
        logic [SLOT_W-1:0] slot;
        logic             banned;
    } verdict_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    logic [ADDR_W-1:0] ban_address [ENTRIES];
    logic [EXP_W-1:0]  ban_expiry [ENTRIES];
    verdict_t          pending_verdicts [$];
    logic [ADDR_W-1:0] recent_addrs [$];
    longint            clock_ms;
    int                mismatches;
    bit                gaps_on;
    bit                stalls_on;
    bit                rx_hold_req;

    expiring_block_list_table_top #(
        .ENTRIES(ENTRIES)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic verdict_t ban_table_step(input logic cmd, input logic [ADDR_W-1:0] addr,
                                                input logic [SECS_W-1:0] secs,
                                                input logic [NOW_W-1:0] now_ms);
        verdict_t         v;
        int               pick;
        int               oldest;
        logic [EXP_W-1:0] oldest_exp;
        logic [EXP_W-1:0] now32;
        v = '0;
        pick = -1;
        oldest = 0;
        oldest_exp = '0;
        now32 = {1'b0, now_ms};
        if (cmd == CMD_ADD) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (ban_expiry[i] == '0 || ban_expiry[i] < now32) begin
                    pick = i;
                    break;
                end
                if (i == 0 || ban_expiry[i] < oldest_exp) begin
                    oldest_exp = ban_expiry[i];
                    oldest = i;
                end
            end
            if (pick < 0) begin
                pick = oldest;
                v.evicted = 1'b1;
            end
            ban_address[pick] = addr;
            ban_expiry[pick] = now32 + EXP_W'(secs) * MS_PER_SECOND;
            v.slot = SLOT_W'(pick);
        end else begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (ban_expiry[i] != '0 && ban_expiry[i] > now32 && ban_address[i] == addr) begin
                    v.banned = 1'b1;
                    v.slot = SLOT_W'(i);
                    break;
                end
            end
        end
        return v;
    endfunction

    task automatic send_word(input logic cmd, input logic [ADDR_W-1:0] addr,
                             input logic [SECS_W-1:0] secs, input logic [NOW_W-1:0] now_ms);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, now_ms, secs, addr};
        s_tuser  <= cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_verdicts.push_back(ban_table_step(cmd, addr, secs, now_ms));
        if (cmd == CMD_ADD) begin
            recent_addrs.push_back(addr);
            if (recent_addrs.size() > 24) recent_addrs.pop_front();
        end
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_verdicts.size() != 0) @(posedge aclk);
    endtask

    task automatic send_random_word;
        logic              cmd;
        logic [ADDR_W-1:0] addr;
        logic [SECS_W-1:0] secs;
        logic [NOW_W-1:0]  now_ms;
        int                pick;
        int                roll;
        clock_ms += $urandom_range(0, 2500);
        if (clock_ms > 64'h7F00_0000) clock_ms = 200_000_000;
        now_ms = clock_ms[NOW_W-1:0];
        if ($urandom_range(0, 19) == 0) begin
            pick = $urandom_range(0, ENTRIES - 1);
            if (ban_expiry[pick] != '0 && !ban_expiry[pick][EXP_W-1])
                now_ms = ban_expiry[pick][NOW_W-1:0];
        end
        cmd = ($urandom_range(0, 99) < 45) ? CMD_ADD : CMD_QUERY;
        addr = {$urandom, $urandom};
        roll = $urandom_range(0, 99);
        if (recent_addrs.size() != 0 && roll < ((cmd == CMD_ADD) ? 20 : 75))
            addr = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
        roll = $urandom_range(0, 99);
        if (roll < 72) secs = SECS_W'($urandom_range(0, 4));
        else if (roll < 93) secs = SECS_W'($urandom_range(0, 120));
        else secs = SECS_W'($urandom_range(0, 65535));
        send_word(cmd, addr, secs, now_ms);
    endtask

    task automatic test_directed;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] c;
        logic [ADDR_W-1:0] d;
        logic [ADDR_W-1:0] e;
        a = {$urandom, $urandom};
        c = 64'hAAAA_AAAA_AAAA_AAAA;
        d = 64'h5555_5555_5555_5555;
        e = {$urandom, $urandom};
        send_word(CMD_QUERY, '0, '0, '0);
        send_word(CMD_QUERY, '1, '1, '1);
        send_word(CMD_ADD, a, 16'd0, 31'd0);
        send_word(CMD_QUERY, a, 16'd0, 31'd0);
        send_word(CMD_ADD, e, 16'd0, 31'd0);
        send_word(CMD_ADD, c, 16'd1, 31'd100);
        send_word(CMD_QUERY, c, 16'd0, 31'd1099);
        send_word(CMD_QUERY, c, 16'd0, 31'd1100);
        send_word(CMD_ADD, d, 16'd2, 31'd1100);
        send_word(CMD_ADD, e, 16'd5, 31'd1101);
        send_word(CMD_QUERY, d, 16'hFFFF, 31'd3000);
        send_word(CMD_QUERY, e, 16'd0, 31'd3000);
        send_word(CMD_ADD, '0, 16'hFFFF, 31'd5000);
        send_word(CMD_QUERY, '0, 16'd0, 31'd5000);
        send_word(CMD_ADD, '1, 16'hFFFF, '1);
        send_word(CMD_QUERY, '1, 16'd0, '1);
        send_word(CMD_QUERY, '0, 16'd0, '1);
        send_word(CMD_QUERY, '1, 16'd0, 31'd0);
        send_word(CMD_ADD, a, 16'd0, '1);
        send_word(CMD_QUERY, a, 16'd0, '1);
        send_word(CMD_QUERY, a, SECS_W'($urandom_range(0, 65535)), 31'h7FFF_FFFE);
        drain;
    endtask

    task automatic test_table_full;
        logic [NOW_W-1:0] t0;
        t0 = 31'd200_000_000;
        for (int i = 0; i < ENTRIES + 6; i++)
            send_word(CMD_ADD, {$urandom, $urandom}, SECS_W'($urandom_range(1, 3)), t0);
        for (int i = 0; i < 8; i++)
            send_word(CMD_QUERY, recent_addrs[$urandom_range(0, recent_addrs.size() - 1)],
                      SECS_W'($urandom_range(0, 65535)),
                      NOW_W'(t0 + $urandom_range(0, 3500)));
        drain;
        clock_ms = 200_010_000;
    endtask

    task automatic test_backpressure;
        rx_hold_req = 1'b1;
        for (int i = 0; i < 12; i++) send_random_word();
        drain;
    endtask

    task automatic test_random;
        for (int i = 0; i < 940; i++) begin
            if (i % 150 == 0) begin
                gaps_on = ($urandom_range(0, 3) != 0);
                stalls_on = ($urandom_range(0, 3) != 0);
            end
            send_random_word();
        end
        drain;
    endtask

    task automatic test_back_to_back;
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        for (int i = 0; i < 100; i++) send_random_word();
        drain;
    endtask

    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                rx_hold_req = 1'b0;
                m_tready <= 1'b1;
            end else if (stalls_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13) - 1) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        verdict_t got;
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: banned %b slot %0d evicted %b",
                             got.banned, got.slot, got.evicted);
            end else begin
                want = pending_verdicts.pop_front();
                if (got.banned !== want.banned || got.slot !== want.slot
                        || got.evicted !== want.evicted) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected banned %b slot %0d evicted %b, got %b %0d %b",
                                 want.banned, want.slot, want.evicted,
                                 got.banned, got.slot, got.evicted);
                end
            end
        end
    end

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        mismatches = 0;
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        rx_hold_req = 1'b0;
        clock_ms = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            ban_address[i] = '0;
            ban_expiry[i] = '0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_table_full();
        test_backpressure();
        test_random();
        test_back_to_back();
        repeat (ENTRIES + 8) @(posedge aclk);
        mismatches += pending_verdicts.size();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
